// ===== hdl/mtl_pkg.sv =====
// Shared types and constants for the model text lexer.
// Holds the scan modes, token types, character codes and the result record.
// No dependencies.
package mtl_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned TypeW = 4;

    // Scan modes, one-hot.
    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_STRING  = 4'b0010,
        MODE_COMMENT = 4'b0100,
        MODE_SKIPWS  = 4'b1000
    } scan_mode_t;

    typedef enum logic [TypeW-1:0] {
        TY_INVALID = 4'd0,
        TY_KEYWORD = 4'd1,
        TY_INT     = 4'd2,
        TY_FLOAT   = 4'd3,
        TY_STRING  = 4'd4,
        TY_LPAREN  = 4'd5,
        TY_RPAREN  = 4'd6,
        TY_LBRACE  = 4'd7,
        TY_RBRACE  = 4'd8
    } tok_type_t;

    localparam logic [ByteW-1:0] CH_MINUS  = 8'h2D;
    localparam logic [ByteW-1:0] CH_DOT    = 8'h2E;
    localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
    localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
    localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
    localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
    localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
    localparam logic [ByteW-1:0] CH_LPAREN = 8'h28;
    localparam logic [ByteW-1:0] CH_RPAREN = 8'h29;
    localparam logic [ByteW-1:0] CH_LBRACE = 8'h7B;
    localparam logic [ByteW-1:0] CH_RBRACE = 8'h7D;
    localparam logic [ByteW-1:0] CH_QUOTE  = 8'h22;
    localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
    localparam logic [ByteW-1:0] CH_NINE   = 8'h39;
    localparam logic [ByteW-1:0] CH_UP_A   = 8'h41;
    localparam logic [ByteW-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [ByteW-1:0] CH_LO_A   = 8'h61;
    localparam logic [ByteW-1:0] CH_LO_Z   = 8'h7A;

    typedef struct packed {
        logic             valid;
        logic             char_valid;
        logic [ByteW-1:0] char_value;
        logic             clear_token;
        logic             token_end;
        tok_type_t        token_class;
    } scan_result_t;

endpackage

// ===== hdl/mtl_scan.sv =====
// Combinational scanner step: classifies one byte and computes the next
// scan state and the optional result. Depends on mtl_pkg.
module mtl_scan
(
    input  logic                           kind,
    input  logic [mtl_pkg::ByteW-1:0]      byte_value,
    input  mtl_pkg::scan_mode_t            mode,
    input  mtl_pkg::tok_type_t             cur_type,
    output mtl_pkg::scan_mode_t            mode_next,
    output mtl_pkg::tok_type_t             type_next,
    output mtl_pkg::scan_result_t          result
);

    logic is_space;
    logic is_letter;
    logic is_digit;
    logic is_bracket;
    logic do_normal;
    logic type_is_number;
    mtl_pkg::tok_type_t bracket_type;

    assign is_space = (byte_value == mtl_pkg::CH_SPACE) || (byte_value == mtl_pkg::CH_TAB)
                   || (byte_value == mtl_pkg::CH_CR) || (byte_value == mtl_pkg::CH_LF);
    assign is_letter = ((byte_value >= mtl_pkg::CH_UP_A) && (byte_value <= mtl_pkg::CH_UP_Z))
                    || ((byte_value >= mtl_pkg::CH_LO_A) && (byte_value <= mtl_pkg::CH_LO_Z));
    assign is_digit = ((byte_value >= mtl_pkg::CH_ZERO) && (byte_value <= mtl_pkg::CH_NINE))
                   || (byte_value == mtl_pkg::CH_MINUS);
    assign is_bracket = (byte_value == mtl_pkg::CH_LPAREN) || (byte_value == mtl_pkg::CH_RPAREN)
                     || (byte_value == mtl_pkg::CH_LBRACE) || (byte_value == mtl_pkg::CH_RBRACE);
    assign type_is_number = (cur_type == mtl_pkg::TY_KEYWORD) || (cur_type == mtl_pkg::TY_INT)
                         || (cur_type == mtl_pkg::TY_FLOAT);

    always_comb
    begin
        priority if (byte_value == mtl_pkg::CH_LPAREN)
            bracket_type = mtl_pkg::TY_LPAREN;
        else if (byte_value == mtl_pkg::CH_RPAREN)
            bracket_type = mtl_pkg::TY_RPAREN;
        else if (byte_value == mtl_pkg::CH_LBRACE)
            bracket_type = mtl_pkg::TY_LBRACE;
        else
            bracket_type = mtl_pkg::TY_RBRACE;
    end

    always_comb
    begin
        mode_next = mode;
        type_next = cur_type;
        result    = '0;
        do_normal = 1'b0;

        if (kind)
        begin
            mode_next          = mtl_pkg::MODE_NORMAL;
            type_next          = mtl_pkg::TY_INVALID;
            result.valid       = 1'b1;
            result.token_end   = 1'b1;
            result.token_class = cur_type;
        end
        else
        begin
            unique case (mode)
                mtl_pkg::MODE_STRING:
                begin
                    result.valid       = 1'b1;
                    result.token_class = mtl_pkg::TY_STRING;
                    if (byte_value == mtl_pkg::CH_QUOTE)
                    begin
                        mode_next        = mtl_pkg::MODE_NORMAL;
                        type_next        = mtl_pkg::TY_INVALID;
                        result.token_end = 1'b1;
                    end
                    else
                    begin
                        result.char_valid = 1'b1;
                        result.char_value = byte_value;
                    end
                end
                mtl_pkg::MODE_COMMENT:
                begin
                    if (byte_value == mtl_pkg::CH_LF)
                        mode_next = mtl_pkg::MODE_SKIPWS;
                end
                mtl_pkg::MODE_SKIPWS:
                begin
                    do_normal = !is_space;
                end
                mtl_pkg::MODE_NORMAL:
                begin
                    do_normal = 1'b1;
                end
                default:
                begin
                    do_normal = 1'b1;
                end
            endcase
        end

        if (do_normal)
        begin
            mode_next = mtl_pkg::MODE_NORMAL;
            priority if (is_letter || is_digit)
            begin
                if (cur_type == mtl_pkg::TY_INVALID)
                    type_next = is_letter ? mtl_pkg::TY_KEYWORD : mtl_pkg::TY_INT;
                result.valid       = 1'b1;
                result.char_valid  = 1'b1;
                result.char_value  = byte_value;
                result.token_class = type_next;
            end
            else if (is_space)
            begin
                // Whitespace closes only keywords and numbers.
                if (type_is_number)
                begin
                    type_next          = mtl_pkg::TY_INVALID;
                    result.valid       = 1'b1;
                    result.token_end   = 1'b1;
                    result.token_class = cur_type;
                end
            end
            else if (byte_value == mtl_pkg::CH_DOT)
            begin
                if (cur_type == mtl_pkg::TY_INT)
                    type_next = mtl_pkg::TY_FLOAT;
                result.valid       = 1'b1;
                result.char_valid  = 1'b1;
                result.char_value  = byte_value;
                result.token_class = type_next;
            end
            else if (is_bracket)
            begin
                type_next          = mtl_pkg::TY_INVALID;
                result.valid       = 1'b1;
                result.char_valid  = 1'b1;
                result.char_value  = byte_value;
                result.token_end   = 1'b1;
                result.token_class = bracket_type;
            end
            else if (byte_value == mtl_pkg::CH_QUOTE)
            begin
                type_next          = mtl_pkg::TY_STRING;
                mode_next          = mtl_pkg::MODE_STRING;
                result.valid       = 1'b1;
                result.clear_token = 1'b1;
                result.token_class = mtl_pkg::TY_STRING;
            end
            else if (byte_value == mtl_pkg::CH_SLASH)
            begin
                mode_next = mtl_pkg::MODE_COMMENT;
            end
            else
            begin
                mode_next = mtl_pkg::MODE_NORMAL;
            end
        end
    end

endmodule

// ===== hdl/model_text_lexer_core.sv =====
// Flow: an accepted transfer is held in the input register, scanned from there,
// and its result (if any) is loaded into the result register that drives the outputs.
// Throughput: one byte per cycle while out_stall is low; the scan mode and token type
// registers update with each scanned byte, so bytes stream without gaps.
// Reset: rst_n clears both valid flags, the scan mode (normal) and the token type.
// Top level of the text lexer. Depends on mtl_pkg and mtl_scan.
module model_text_lexer_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [mtl_pkg::ByteW-1:0] byte_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      char_valid,
    output logic [mtl_pkg::ByteW-1:0] char_value,
    output logic                      clear_token,
    output logic                      token_end,
    output logic [mtl_pkg::TypeW-1:0] token_class
);

    logic                      in_valid_reg;
    logic                      kind_reg;
    logic [mtl_pkg::ByteW-1:0] byte_reg;
    logic                      out_valid_reg;
    mtl_pkg::scan_result_t     result_reg;
    mtl_pkg::scan_mode_t       mode_reg;
    mtl_pkg::scan_mode_t       mode_next;
    mtl_pkg::tok_type_t        type_reg;
    mtl_pkg::tok_type_t        type_next;
    mtl_pkg::scan_result_t     result_next;
    logic                      out_free;
    logic                      scan_fire;
    logic                      in_take;

    // The result register can load when empty or when its transfer completes.
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_fire = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    mtl_scan u_scan
    (
        .kind       (kind_reg),
        .byte_value (byte_reg),
        .mode       (mode_reg),
        .cur_type   (type_reg),
        .mode_next  (mode_next),
        .type_next  (type_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= mtl_pkg::MODE_NORMAL;
            type_reg      <= mtl_pkg::TY_INVALID;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (scan_fire)
                in_valid_reg <= 1'b0;

            if (scan_fire)
            begin
                mode_reg      <= mode_next;
                type_reg      <= type_next;
                out_valid_reg <= result_next.valid;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            byte_reg <= byte_value;
        end
        if (scan_fire)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign char_valid  = result_reg.char_valid;
    assign char_value  = result_reg.char_value;
    assign clear_token = result_reg.clear_token;
    assign token_end   = result_reg.token_end;
    assign token_class = result_reg.token_class;

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> char_value == '0)
        else $error("char_value not zero without a character");

    a_clear_string: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clear_token |-> !token_end && !char_valid
            && token_class == mtl_pkg::TY_STRING)
        else $error("clear_token outside a string start");

    a_end_char_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_end && char_valid |->
            token_class == mtl_pkg::TY_LPAREN || token_class == mtl_pkg::TY_RPAREN
            || token_class == mtl_pkg::TY_LBRACE || token_class == mtl_pkg::TY_RBRACE)
        else $error("token end with a character that is not a bracket");

    a_eoi_reset: assert property (@(posedge clk) disable iff (!rst_n)
        scan_fire && kind_reg |=> mode_reg == mtl_pkg::MODE_NORMAL
            && type_reg == mtl_pkg::TY_INVALID && out_valid_reg)
        else $error("end of input did not return the scanner to reset state");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg && $stable(byte_reg) && $stable(kind_reg))
        else $error("input register changed while stalled");

endmodule
